>>> sv/dsq_pkg.sv
// ----------------------------------------------------------------------------
// dsq_pkg
// Shared types, codes and reset values for the drive safety qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package dsq_pkg;

  // Safety classes and states
  localparam logic [1:0] CLS_SAFE  = 2'd0;
  localparam logic [1:0] CLS_WARN  = 2'd1;
  localparam logic [1:0] CLS_LIMP  = 2'd2;
  localparam logic [1:0] CLS_EMERG = 2'd3;

  // Item actions
  localparam logic [1:0] ACT_EVAL  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_FORCE = 2'd2;

  // Drive event codes
  localparam logic [2:0] EV_STUCK_LEFT  = 3'd1;
  localparam logic [2:0] EV_STUCK_RIGHT = 3'd2;
  localparam logic [2:0] EV_IMBALANCE   = 3'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_CURRENT_LIMP = 3'd0;
  localparam logic [2:0] REG_CURRENT_WARN = 3'd1;
  localparam logic [2:0] REG_TEMP_LIMP    = 3'd2;
  localparam logic [2:0] REG_TEMP_WARN    = 3'd3;
  localparam logic [2:0] REG_LIMP_CONFIRM = 3'd4;
  localparam logic [2:0] REG_WARN_CONFIRM = 3'd5;
  localparam logic [2:0] REG_LIMP_HOLD    = 3'd6;
  localparam logic [2:0] REG_SAFE_SETTLE  = 3'd7;

  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 16;

  // Configuration reset values
  localparam logic [14:0]        RST_CURRENT_LIMP = 15'd2000;
  localparam logic [14:0]        RST_CURRENT_WARN = 15'd1500;
  localparam logic signed [11:0] RST_TEMP_LIMP    = 12'sd850;
  localparam logic signed [11:0] RST_TEMP_WARN    = 12'sd700;
  localparam logic [7:0]         RST_LIMP_CONFIRM = 8'd3;
  localparam logic [7:0]         RST_WARN_CONFIRM = 8'd2;
  localparam logic [15:0]        RST_LIMP_HOLD    = 16'd1500;
  localparam logic [15:0]        RST_SAFE_SETTLE  = 16'd2000;

  localparam logic [7:0] STREAK_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]         action;
    logic               fault_flag;
    logic signed [15:0] current_0;
    logic signed [15:0] current_1;
    logic signed [15:0] current_2;
    logic signed [15:0] current_3;
    logic signed [11:0] temp_left;
    logic signed [11:0] temp_right;
    logic [2:0]         drive_event;
    logic [31:0]        now_ms;
    logic [1:0]         forced_state;
  } dsq_in_t;

  typedef struct packed {
    logic [1:0] raw_class;
    logic [1:0] safety_state;
    logic       stable_ok;
    logic       reset_auto_reverse;
  } dsq_out_t;

  typedef struct packed {
    logic [14:0]        current_limp_limit;
    logic [14:0]        current_warn_limit;
    logic signed [11:0] temp_limp_limit;
    logic signed [11:0] temp_warn_limit;
    logic [7:0]         limp_confirm_count;
    logic [7:0]         warn_confirm_count;
    logic [15:0]        limp_hold_ms;
    logic [15:0]        safe_settle_ms;
  } dsq_cfg_t;

  // What the filter needs of a classified item
  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  raw_class;
    logic [31:0] now_ms;
    logic [1:0]  forced_state;
  } dsq_stage_t;

endpackage

`default_nettype wire

>>> sv/dsq_classify.sv
// ----------------------------------------------------------------------------
// dsq_classify
// Classifies one sample as SAFE, WARN, LIMP or EMERGENCY.
// ----------------------------------------------------------------------------
`default_nettype none

module dsq_classify
  import dsq_pkg::*;
(
  input  wire dsq_in_t  item,
  input  wire dsq_cfg_t cfg,
  output logic [1:0]    raw_class
);

  logic [16:0] mag0, mag1, mag2, mag3;
  logic [16:0] peak01, peak23, peak;
  logic        over_limp, over_warn;

  // Magnitudes are 17 bits so that the most negative current stays exact.
  function automatic logic [16:0] mag17(input logic signed [15:0] v);
    logic signed [16:0] w;
    w = {v[15], v};
    return w[16] ? 17'(-w) : 17'(w);
  endfunction

  always_comb begin
    mag0   = mag17(item.current_0);
    mag1   = mag17(item.current_1);
    mag2   = mag17(item.current_2);
    mag3   = mag17(item.current_3);
    peak01 = (mag0 > mag1) ? mag0 : mag1;
    peak23 = (mag2 > mag3) ? mag2 : mag3;
    peak   = (peak01 > peak23) ? peak01 : peak23;

    over_limp = (peak > {2'b00, cfg.current_limp_limit}) ||
                (item.temp_left > cfg.temp_limp_limit) ||
                (item.temp_right > cfg.temp_limp_limit);
    over_warn = (peak > {2'b00, cfg.current_warn_limit}) ||
                (item.temp_left > cfg.temp_warn_limit) ||
                (item.temp_right > cfg.temp_warn_limit);

    if (item.fault_flag) begin
      raw_class = CLS_EMERG;
    end else if (over_limp || item.drive_event == EV_STUCK_LEFT ||
                 item.drive_event == EV_STUCK_RIGHT) begin
      raw_class = CLS_LIMP;
    end else if (item.drive_event == EV_IMBALANCE || over_warn) begin
      raw_class = CLS_WARN;
    end else begin
      raw_class = CLS_SAFE;
    end
  end

endmodule

`default_nettype wire

>>> sv/dsq_filter.sv
// ----------------------------------------------------------------------------
// dsq_filter
// Safety state filter: confirm streaks, LIMP hold, emergency latch and
// SAFE-stable timing. State advances once for each item that steps.
// ----------------------------------------------------------------------------
`default_nettype none

module dsq_filter
  import dsq_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              step,
  input  wire dsq_stage_t  item,
  input  wire dsq_cfg_t    cfg,
  output dsq_out_t         result
);

  logic [1:0]  state_r, state_nxt;
  logic        latch_r, latch_nxt;
  logic [7:0]  limp_streak_r, limp_streak_nxt;
  logic [7:0]  warn_streak_r, warn_streak_nxt;
  logic [31:0] hold_start_r, hold_start_nxt;
  logic        stable_r, stable_nxt;
  logic        started_r, started_nxt;
  logic [31:0] safe_start_r, safe_start_nxt;
  logic        pulse;
  logic [1:0]  raw_out;
  logic [7:0]  limp_inc, warn_inc;
  logic [31:0] hold_elapsed, safe_elapsed;

  always_comb begin
    state_nxt       = state_r;
    latch_nxt       = latch_r;
    limp_streak_nxt = limp_streak_r;
    warn_streak_nxt = warn_streak_r;
    hold_start_nxt  = hold_start_r;
    stable_nxt      = stable_r;
    started_nxt     = started_r;
    safe_start_nxt  = safe_start_r;
    pulse           = 1'b0;
    raw_out         = CLS_SAFE;

    limp_inc = (limp_streak_r == STREAK_MAX) ? STREAK_MAX : limp_streak_r + 8'd1;
    warn_inc = (warn_streak_r == STREAK_MAX) ? STREAK_MAX : warn_streak_r + 8'd1;

    case (item.action)
      ACT_EVAL: begin
        raw_out = item.raw_class;
        if (latch_r || item.raw_class == CLS_EMERG) begin
          latch_nxt       = 1'b1;
          state_nxt       = CLS_EMERG;
          limp_streak_nxt = '0;
          warn_streak_nxt = '0;
          stable_nxt      = 1'b0;
          started_nxt     = 1'b0;
          safe_start_nxt  = '0;
        end else begin
          if (item.raw_class == CLS_LIMP) begin
            warn_streak_nxt = '0;
            limp_streak_nxt = limp_inc;
            if (limp_inc >= cfg.limp_confirm_count) begin
              state_nxt      = CLS_LIMP;
              hold_start_nxt = item.now_ms;
            end
          end else if (item.raw_class == CLS_WARN) begin
            limp_streak_nxt = '0;
            warn_streak_nxt = warn_inc;
            if (warn_inc >= cfg.warn_confirm_count) begin
              state_nxt = CLS_WARN;
            end
          end else begin
            limp_streak_nxt = '0;
            warn_streak_nxt = '0;
          end

          // A confirmed LIMP is kept until its hold time has run out. When
          // this item confirms LIMP itself the state is LIMP already, so the
          // stored start time serves.
          if (state_r == CLS_LIMP && hold_elapsed < {16'd0, cfg.limp_hold_ms}) begin
            state_nxt = CLS_LIMP;
          end

          if (item.raw_class != CLS_SAFE) begin
            stable_nxt     = 1'b0;
            started_nxt    = 1'b0;
            safe_start_nxt = '0;
          end else if (!stable_r) begin
            if (!started_r) begin
              started_nxt    = 1'b1;
              safe_start_nxt = item.now_ms;
            end else if (safe_elapsed >= {16'd0, cfg.safe_settle_ms}) begin
              stable_nxt = 1'b1;
              state_nxt  = CLS_SAFE;
              pulse      = 1'b1;
            end
          end
        end
      end
      ACT_CLEAR: begin
        latch_nxt = 1'b0;
      end
      ACT_FORCE: begin
        state_nxt       = item.forced_state;
        latch_nxt       = latch_r || (item.forced_state == CLS_EMERG);
        limp_streak_nxt = '0;
        warn_streak_nxt = '0;
        stable_nxt      = 1'b0;
        started_nxt     = 1'b0;
        safe_start_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  assign hold_elapsed = item.now_ms - hold_start_r;
  assign safe_elapsed = item.now_ms - safe_start_r;

  assign result.raw_class          = raw_out;
  assign result.safety_state       = state_nxt;
  assign result.stable_ok          = stable_nxt;
  assign result.reset_auto_reverse = pulse;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= CLS_SAFE;
      latch_r       <= 1'b0;
      limp_streak_r <= '0;
      warn_streak_r <= '0;
      hold_start_r  <= '0;
      stable_r      <= 1'b0;
      started_r     <= 1'b0;
      safe_start_r  <= '0;
    end else if (step) begin
      state_r       <= state_nxt;
      latch_r       <= latch_nxt;
      limp_streak_r <= limp_streak_nxt;
      warn_streak_r <= warn_streak_nxt;
      hold_start_r  <= hold_start_nxt;
      stable_r      <= stable_nxt;
      started_r     <= started_nxt;
      safe_start_r  <= safe_start_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/drive_safety_qualifier.sv
// ----------------------------------------------------------------------------
// drive_safety_qualifier
// Classifies drive samples and filters the class into a safety state.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_ready  dsq_in_t  sample item
//   out_     output     out_valid/out_ready  dsq_out_t result item
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// Each item is classified on the way into the stage register and, when it
// advances, takes the filter's state into the result register. Items
// pass at one item per cycle while the result is not stalled. A stalled
// result holds the result register, and a new item still waits in the
// stage register. Reset is synchronous and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_safety_qualifier
  import dsq_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire dsq_in_t           in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output dsq_out_t               out_data,
  input  wire                    cfg_we,
  input  wire [CfgIndexW-1:0]    cfg_index,
  input  wire [CfgDataW-1:0]     cfg_wdata
);

  dsq_cfg_t   cfg_r;
  dsq_stage_t stage_r, stage_nxt;
  logic       stage_valid_r;
  dsq_out_t   out_r, result;
  logic       out_valid_r;
  logic [1:0] raw_class;
  logic       advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.current_limp_limit <= RST_CURRENT_LIMP;
      cfg_r.current_warn_limit <= RST_CURRENT_WARN;
      cfg_r.temp_limp_limit    <= RST_TEMP_LIMP;
      cfg_r.temp_warn_limit    <= RST_TEMP_WARN;
      cfg_r.limp_confirm_count <= RST_LIMP_CONFIRM;
      cfg_r.warn_confirm_count <= RST_WARN_CONFIRM;
      cfg_r.limp_hold_ms       <= RST_LIMP_HOLD;
      cfg_r.safe_settle_ms     <= RST_SAFE_SETTLE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURRENT_LIMP: cfg_r.current_limp_limit <= cfg_wdata[14:0];
        REG_CURRENT_WARN: cfg_r.current_warn_limit <= cfg_wdata[14:0];
        REG_TEMP_LIMP:    cfg_r.temp_limp_limit    <= cfg_wdata[11:0];
        REG_TEMP_WARN:    cfg_r.temp_warn_limit    <= cfg_wdata[11:0];
        REG_LIMP_CONFIRM: cfg_r.limp_confirm_count <= cfg_wdata[7:0];
        REG_WARN_CONFIRM: cfg_r.warn_confirm_count <= cfg_wdata[7:0];
        REG_LIMP_HOLD:    cfg_r.limp_hold_ms       <= cfg_wdata;
        REG_SAFE_SETTLE:  cfg_r.safe_settle_ms     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  dsq_classify u_classify (
    .item      (in_data),
    .cfg       (cfg_r),
    .raw_class (raw_class)
  );

  assign stage_nxt.action       = in_data.action;
  assign stage_nxt.raw_class    = raw_class;
  assign stage_nxt.now_ms       = in_data.now_ms;
  assign stage_nxt.forced_state = in_data.forced_state;

  // The staged item moves on, and updates the state, when the result
  // register is free or being emptied.
  assign advance  = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stage_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_r <= stage_nxt;
    end
  end

  dsq_filter u_filter (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (stage_r),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> verif/dsq_checker.sv
// ----------------------------------------------------------------------------
// dsq_checker
// Watches the drive safety qualifier's channels, predicts every result item
// from its own copy of the classifier, the filter state and the registers,
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsq_checker
  import dsq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  dsq_in_t              in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  dsq_out_t             out_data,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_wdata,
  output int                   errors,
  output int                   pending
);

  dsq_cfg_t    cfg;
  logic [1:0]  safety_now;
  logic        latched;
  logic [7:0]  limp_run;
  logic [7:0]  warn_run;
  logic [31:0] hold_start;
  logic        safe_confirmed;
  logic        safe_timing;
  logic [31:0] safe_since;

  dsq_out_t    expected_verdicts[$];
  int          fail_count = 0;
  int          queue_depth = 0;

  assign errors  = fail_count;
  assign pending = queue_depth;

  function automatic logic [1:0] classify_sample(dsq_in_t s);
    int peak;
    int mag;
    int tl;
    int tr;
    int t_limp;
    int t_warn;
    int k;
    logic signed [15:0] chan [4];
    chan[0] = s.current_0;
    chan[1] = s.current_1;
    chan[2] = s.current_2;
    chan[3] = s.current_3;
    if (s.fault_flag) return CLS_EMERG;
    peak = 0;
    for (k = 0; k < 4; k++) begin
      mag = chan[k];
      if (mag < 0) mag = -mag;
      if (mag > peak) peak = mag;
    end
    tl     = s.temp_left;
    tr     = s.temp_right;
    t_limp = cfg.temp_limp_limit;
    t_warn = cfg.temp_warn_limit;
    if (peak > int'(cfg.current_limp_limit) || tl > t_limp || tr > t_limp) return CLS_LIMP;
    if (s.drive_event == EV_STUCK_LEFT || s.drive_event == EV_STUCK_RIGHT) return CLS_LIMP;
    if (s.drive_event == EV_IMBALANCE) return CLS_WARN;
    if (peak > int'(cfg.current_warn_limit) || tl > t_warn || tr > t_warn) return CLS_WARN;
    return CLS_SAFE;
  endfunction

  function automatic void drop_safe_run();
    safe_confirmed = 1'b0;
    safe_timing    = 1'b0;
    safe_since     = '0;
  endfunction

  task automatic qualify_item(input dsq_in_t s, output dsq_out_t r);
    logic [1:0] raw;
    logic [1:0] nxt;
    logic       pulse;
    raw   = CLS_SAFE;
    pulse = 1'b0;
    case (s.action)
      ACT_EVAL: begin
        raw = classify_sample(s);
        if (raw == CLS_EMERG) latched = 1'b1;
        if (latched) begin
          safety_now = CLS_EMERG;
          limp_run   = '0;
          warn_run   = '0;
          drop_safe_run();
        end else begin
          nxt = safety_now;
          if (raw == CLS_LIMP) begin
            warn_run = '0;
            if (limp_run != STREAK_MAX) limp_run = limp_run + 8'd1;
            if (limp_run >= cfg.limp_confirm_count) begin
              nxt        = CLS_LIMP;
              hold_start = s.now_ms;
            end
          end else if (raw == CLS_WARN) begin
            limp_run = '0;
            if (warn_run != STREAK_MAX) warn_run = warn_run + 8'd1;
            if (warn_run >= cfg.warn_confirm_count) nxt = CLS_WARN;
          end else begin
            limp_run = '0;
            warn_run = '0;
          end
          // The hold is measured from the latest confirmation, with wrapping time.
          if (safety_now == CLS_LIMP &&
              32'(s.now_ms - hold_start) < {16'd0, cfg.limp_hold_ms}) begin
            nxt = CLS_LIMP;
          end
          safety_now = nxt;
          if (raw != CLS_SAFE) begin
            drop_safe_run();
          end else if (!safe_confirmed) begin
            if (!safe_timing) begin
              safe_timing = 1'b1;
              safe_since  = s.now_ms;
            end else if (32'(s.now_ms - safe_since) >= {16'd0, cfg.safe_settle_ms}) begin
              safe_confirmed = 1'b1;
              safety_now     = CLS_SAFE;
              pulse          = 1'b1;
            end
          end
        end
      end
      ACT_CLEAR: latched = 1'b0;
      ACT_FORCE: begin
        safety_now = s.forced_state;
        if (safety_now == CLS_EMERG) latched = 1'b1;
        limp_run = '0;
        warn_run = '0;
        drop_safe_run();
      end
      default: ;
    endcase
    r.raw_class          = raw;
    r.safety_state       = safety_now;
    r.stable_ok          = safe_confirmed;
    r.reset_auto_reverse = pulse;
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    dsq_out_t want;
    if (!rst_n) begin
      cfg.current_limp_limit = RST_CURRENT_LIMP;
      cfg.current_warn_limit = RST_CURRENT_WARN;
      cfg.temp_limp_limit    = RST_TEMP_LIMP;
      cfg.temp_warn_limit    = RST_TEMP_WARN;
      cfg.limp_confirm_count = RST_LIMP_CONFIRM;
      cfg.warn_confirm_count = RST_WARN_CONFIRM;
      cfg.limp_hold_ms       = RST_LIMP_HOLD;
      cfg.safe_settle_ms     = RST_SAFE_SETTLE;
      safety_now = CLS_SAFE;
      latched    = 1'b0;
      limp_run   = '0;
      warn_run   = '0;
      hold_start = '0;
      drop_safe_run();
      expected_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CURRENT_LIMP: cfg.current_limp_limit = cfg_wdata[14:0];
          REG_CURRENT_WARN: cfg.current_warn_limit = cfg_wdata[14:0];
          REG_TEMP_LIMP:    cfg.temp_limp_limit    = cfg_wdata[11:0];
          REG_TEMP_WARN:    cfg.temp_warn_limit    = cfg_wdata[11:0];
          REG_LIMP_CONFIRM: cfg.limp_confirm_count = cfg_wdata[7:0];
          REG_WARN_CONFIRM: cfg.warn_confirm_count = cfg_wdata[7:0];
          REG_LIMP_HOLD:    cfg.limp_hold_ms       = cfg_wdata;
          REG_SAFE_SETTLE:  cfg.safe_settle_ms     = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result item %p arrived with nothing expected", $time, out_data);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          check_field("raw_class", want.raw_class, out_data.raw_class);
          check_field("safety_state", want.safety_state, out_data.safety_state);
          check_field("stable_ok", want.stable_ok, out_data.stable_ok);
          check_field("reset_auto_reverse", want.reset_auto_reverse,
                      out_data.reset_auto_reverse);
        end
      end
      if (in_valid && in_ready) begin
        qualify_item(in_data, want);
        expected_verdicts.push_back(want);
      end
    end
    queue_depth = expected_verdicts.size();
  end

endmodule

>>> verif/drive_safety_qualifier_tb.sv
// ----------------------------------------------------------------------------
// drive_safety_qualifier_tb
// Drives sample items through the drive safety qualifier under several
// register settings: a directed opening, then phases of random sequences
// with idling on both channels and one long stall of the result channel.
// A checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module drive_safety_qualifier_tb;
  import dsq_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_OTHER   = 3'd4;
  localparam int MIXED     = 0;
  localparam int LIMP_ONLY = 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL  = 80;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  dsq_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  dsq_out_t             out_data;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_wdata = '0;
  int                   errors;
  int                   pending;

  dsq_cfg_t    cfg_now;
  logic [31:0] clock_ms = '0;
  logic        idle_on = 1'b1;
  logic        held_off = 1'b0;
  int          sent_count = 0;
  int          hold_at = 32'h7FFF_FFFF;
  int          cycle_count = 0;

  drive_safety_qualifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dsq_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int rand_between(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic logic signed [15:0] signed_current(int mag);
    if (mag >= 32768) return 16'sh8000;
    return $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
  endfunction

  // A sample at the current time with every field at rest.
  function automatic dsq_in_t still_sample(logic [31:0] t);
    dsq_in_t s;
    s        = '0;
    s.action = ACT_EVAL;
    s.now_ms = t;
    return s;
  endfunction

  // Builds a sample aimed at one class under the registers now in force.
  function automatic dsq_in_t build_sample(logic [1:0] target);
    dsq_in_t s;
    int cur_warn;
    int cur_limp;
    int t_warn;
    int t_limp;
    int cur_cap;
    int t_cap;
    int ch;
    int k;
    logic signed [15:0] chan [4];
    cur_warn = cfg_now.current_warn_limit;
    cur_limp = cfg_now.current_limp_limit;
    t_warn   = cfg_now.temp_warn_limit;
    t_limp   = cfg_now.temp_limp_limit;
    cur_cap  = (cur_warn < cur_limp) ? cur_warn : cur_limp;
    t_cap    = (t_warn < t_limp) ? t_warn : t_limp;
    s = still_sample(clock_ms);
    s.forced_state = 2'($urandom_range(0, 3));
    for (k = 0; k < 4; k++) chan[k] = signed_current(rand_between(0, cur_cap));
    s.temp_left  = 12'(rand_between(-550, t_cap));
    s.temp_right = 12'(rand_between(-550, t_cap));
    case ($urandom_range(0, 9))
      0, 1:    s.drive_event = EV_OTHER;
      2:       s.drive_event = 3'($urandom_range(5, 7));
      default: s.drive_event = EV_NONE;
    endcase
    ch = $urandom_range(0, 3);
    case (target)
      CLS_WARN: begin
        k = $urandom_range(0, 2);
        if (k == 0 && cur_warn < cur_limp) begin
          chan[ch] = signed_current(rand_between(cur_warn + 1, cur_limp));
        end else if (k == 1 && t_warn < t_limp) begin
          s.temp_left = 12'(rand_between(t_warn + 1, t_limp));
        end else begin
          s.drive_event = EV_IMBALANCE;
        end
      end
      CLS_LIMP: begin
        k = $urandom_range(0, 3);
        if (k == 0) begin
          chan[ch] = signed_current(rand_between(cur_limp + 1, 32768));
        end else if (k == 1 && t_limp < 1500) begin
          s.temp_right = 12'(rand_between(t_limp + 1, 1500));
        end else begin
          s.drive_event = $urandom_range(0, 1) ? EV_STUCK_LEFT : EV_STUCK_RIGHT;
        end
      end
      CLS_EMERG: s.fault_flag = 1'b1;
      default: ;
    endcase
    s.current_0 = chan[0];
    s.current_1 = chan[1];
    s.current_2 = chan[2];
    s.current_3 = chan[3];
    return s;
  endfunction

  task automatic send_item(input dsq_in_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  task automatic idle_input(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    idle_input(1);
    wait (pending == 0);
  endtask

  task automatic apply_config(input int cl, input int cw, input int tl, input int tw,
                              input int lc, input int wc, input int hold, input int stable);
    cfg_now.current_limp_limit = 15'(cl);
    cfg_now.current_warn_limit = 15'(cw);
    cfg_now.temp_limp_limit    = 12'(tl);
    cfg_now.temp_warn_limit    = 12'(tw);
    cfg_now.limp_confirm_count = 8'(lc);
    cfg_now.warn_confirm_count = 8'(wc);
    cfg_now.limp_hold_ms       = 16'(hold);
    cfg_now.safe_settle_ms     = 16'(stable);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CURRENT_LIMP;
    cfg_wdata <= 16'(cl);
    @(negedge clk);
    cfg_index <= REG_CURRENT_WARN;
    cfg_wdata <= 16'(cw);
    @(negedge clk);
    cfg_index <= REG_TEMP_LIMP;
    cfg_wdata <= 16'(tl);
    @(negedge clk);
    cfg_index <= REG_TEMP_WARN;
    cfg_wdata <= 16'(tw);
    @(negedge clk);
    cfg_index <= REG_LIMP_CONFIRM;
    cfg_wdata <= 16'(lc);
    @(negedge clk);
    cfg_index <= REG_WARN_CONFIRM;
    cfg_wdata <= 16'(wc);
    @(negedge clk);
    cfg_index <= REG_LIMP_HOLD;
    cfg_wdata <= 16'(hold);
    @(negedge clk);
    cfg_index <= REG_SAFE_SETTLE;
    cfg_wdata <= 16'(stable);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Runs of one class build up streaks and stable SAFE stretches; clears,
  // forces and fully random items break them up.
  task automatic run_phase(input int count, input int mode, input int step_max);
    int n;
    int roll;
    int run_left;
    logic [1:0] run_class;
    dsq_in_t it;
    run_left  = 0;
    run_class = CLS_SAFE;
    for (n = 0; n < count; n++) begin
      if (idle_on && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 19));
      clock_ms = clock_ms + $urandom_range(0, step_max);
      if (run_left == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          run_class = CLS_SAFE;
          run_left  = $urandom_range(1, 12);
        end else if (roll < 65) begin
          run_class = CLS_WARN;
          run_left  = $urandom_range(1, 6);
        end else if (roll < 93) begin
          run_class = CLS_LIMP;
          run_left  = $urandom_range(1, 8);
        end else begin
          run_class = CLS_EMERG;
          run_left  = 1;
        end
      end
      run_left--;
      roll = $urandom_range(0, 99);
      if (mode == LIMP_ONLY) begin
        it = build_sample(CLS_LIMP);
        if (roll < 4) it.action = ACT_CLEAR;
        else if (roll < 6) it.action = ACT_UNUSED;
      end else begin
        it = build_sample(run_class);
        if (roll < 3) it = {$urandom, $urandom, $urandom, $urandom};
        else if (roll < 9) it.action = ACT_CLEAR;
        else if (roll < 15) it.action = ACT_FORCE;
        else if (roll < 17) it.action = ACT_UNUSED;
      end
      send_item(it);
    end
  endtask

  // Result side: random stalls, and once a long hold-off while items keep coming.
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      @(negedge clk);
      stall = 0;
      if (!held_off && sent_count >= hold_at) begin
        held_off = 1'b1;
        stall    = LONG_STALL;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 19);
      end
      if (stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
    end
  end

  initial begin
    dsq_in_t it;
    logic [31:0] t;
    cfg_now.current_limp_limit = RST_CURRENT_LIMP;
    cfg_now.current_warn_limit = RST_CURRENT_WARN;
    cfg_now.temp_limp_limit    = RST_TEMP_LIMP;
    cfg_now.temp_warn_limit    = RST_TEMP_WARN;
    cfg_now.limp_confirm_count = RST_LIMP_CONFIRM;
    cfg_now.warn_confirm_count = RST_WARN_CONFIRM;
    cfg_now.limp_hold_ms       = RST_LIMP_HOLD;
    cfg_now.safe_settle_ms     = RST_SAFE_SETTLE;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening under the reset register values.
    t = 32'd0;
    send_item(still_sample(t));                // SAFE run starts at time zero
    t = 32'd2000;
    send_item(still_sample(t));                // stable SAFE confirmed
    send_item(still_sample(t + 1));
    t = 32'd2100;
    it = still_sample(t); it.current_0 = 16'sh7FFF; send_item(it);
    it = still_sample(t); it.current_1 = 16'sh8000; send_item(it);
    it = still_sample(t); it.current_2 = 16'sd2001; it.current_3 = -16'sd2001; send_item(it);
    it = still_sample(t); it.temp_left = 12'sd1500; it.temp_right = -12'sd550; send_item(it);
    it = still_sample(t); it.drive_event = EV_STUCK_LEFT; send_item(it);
    it = still_sample(t); it.drive_event = EV_STUCK_RIGHT; send_item(it);
    it = still_sample(t + 10); it.drive_event = EV_IMBALANCE; send_item(it);
    t = 32'd4000;
    it = still_sample(t); it.temp_right = 12'sd701; send_item(it);
    it = still_sample(t); it.current_1 = 16'sd1500; it.drive_event = EV_OTHER; send_item(it);
    it = still_sample(t); it.drive_event = 3'd5; send_item(it);
    it = still_sample(t); it.drive_event = 3'd6; send_item(it);
    it = still_sample(t); it.drive_event = 3'd7; it.current_2 = 16'sd1501; send_item(it);
    it = still_sample(t); it.fault_flag = 1'b1; send_item(it);
    send_item(still_sample(t + 5000));         // latch holds EMERGENCY
    it = still_sample(t); it.action = ACT_CLEAR; send_item(it);
    it = still_sample(t); it.action = ACT_FORCE; it.forced_state = CLS_WARN; send_item(it);
    it = still_sample(t); it.action = ACT_FORCE; it.forced_state = CLS_LIMP; send_item(it);
    it = still_sample(t); it.action = ACT_FORCE; it.forced_state = CLS_EMERG; send_item(it);
    it = still_sample(t); it.action = ACT_CLEAR; send_item(it);
    it = still_sample(t); it.action = ACT_FORCE; it.forced_state = CLS_SAFE; send_item(it);
    it = still_sample(t); it.action = ACT_UNUSED; it.fault_flag = 1'b1; send_item(it);
    send_item(still_sample(t + 1));
    clock_ms = t + 2;

    drain();
    apply_config(1200, 800, 600, 400, 1, 0, 0, 0);
    run_phase(80, MIXED, 300);

    drain();
    apply_config(2000, 1500, 850, 700, 3, 2, 1500, 2000);
    hold_at = sent_count + 40;
    run_phase(90, MIXED, 500);

    // Long LIMP runs take the LIMP streak counter to saturation.
    drain();
    apply_config(32767, 32767, 1500, 1500, 255, 255, 65535, 65535);
    run_phase(275, LIMP_ONLY, 4000);
    run_phase(15, MIXED, 4000);

    // Lowest limits, with the timestamp wrapping through zero.
    drain();
    apply_config(0, 0, -550, -550, 0, 0, 1000, 500);
    clock_ms = 32'hFFFF_FE00;
    run_phase(60, MIXED, 120);

    drain();
    idle_on = 1'b0;
    apply_config(900, 2500, 300, 1200, 2, 4, 700, 900);
    run_phase(40, MIXED, 300);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
